@@ hdl/lbcs_pkg.sv @@
package lbcs_pkg;

    // Table geometry and search window.
    localparam int ROWS        = 128;
    localparam int SEARCH_LOW  = 5;
    localparam int SEARCH_HIGH = 110;

    localparam int ADDR_W  = $clog2(ROWS);
    localparam int SCAN_W  = ADDR_W + 1;
    localparam int COL_W   = 8;
    localparam int ROW_W   = 7;
    localparam int TEAR_W  = 7;
    localparam int KIND_W  = 2;
    localparam int CMP_W   = (SCAN_W > TEAR_W) ? SCAN_W : TEAR_W;

    // Nine-row window around the candidate row; the candidate sits in the middle.
    localparam int WIN     = 9;
    localparam int WIN_C   = 4;
    localparam int WCNT_W  = $clog2(WIN + 1);

    localparam int QDEPTH  = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEAR = 3'd4;

    // For a row write, lo carries the row and hi is unused.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SCAN_W-1:0] lo;
        logic [SCAN_W-1:0] hi;
        logic [COL_W-1:0]  lx;
        logic [COL_W-1:0]  rx;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0]  flat;
        logic [COL_W-1:0]  near;
        logic [COL_W-1:0]  mid;
        logic [COL_W-1:0]  far;
        logic [TEAR_W-1:0] tear;
    } t_cfg;

    typedef logic [WIN-1:0][COL_W-1:0] t_win;

    function automatic logic [COL_W-1:0] col_dist(input logic [COL_W-1:0] a,
                                                  input logic [COL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Signed jump test: (c - x) >= j on the left side, (x - c) >= j on the right.
    function automatic logic jump_ok(input logic [COL_W-1:0] c, input logic [COL_W-1:0] x,
                                     input logic left, input logic [COL_W-1:0] j);
        logic [COL_W:0] d;
        d = left ? ({1'b0, c} - {1'b0, x}) : ({1'b0, x} - {1'b0, c});
        return !d[COL_W] && (d[COL_W-1:0] >= j);
    endfunction

    // Window index k holds row (candidate - WIN_C + k).
    function automatic logic corner(input t_win w, input logic up, input logic left,
                                    input t_cfg cfg);
        logic flat;
        logic jump;
        if (!up) begin
            flat = (col_dist(w[WIN_C], w[WIN_C-1]) <= cfg.flat) &&
                   (col_dist(w[WIN_C-1], w[WIN_C-2]) <= cfg.flat) &&
                   (col_dist(w[WIN_C-2], w[WIN_C-3]) <= cfg.flat);
            jump = jump_ok(w[WIN_C], w[WIN_C+2], left, cfg.near) &&
                   jump_ok(w[WIN_C], w[WIN_C+3], left, cfg.mid) &&
                   jump_ok(w[WIN_C], w[WIN_C+4], left, cfg.far);
        end else begin
            flat = (col_dist(w[WIN_C], w[WIN_C+1]) <= cfg.flat) &&
                   (col_dist(w[WIN_C+1], w[WIN_C+2]) <= cfg.flat) &&
                   (col_dist(w[WIN_C+2], w[WIN_C+3]) <= cfg.flat);
            jump = jump_ok(w[WIN_C], w[WIN_C-2], left, cfg.near) &&
                   jump_ok(w[WIN_C], w[WIN_C-3], left, cfg.mid) &&
                   jump_ok(w[WIN_C], w[WIN_C-4], left, cfg.far);
        end
        return flat && jump;
    endfunction

endpackage

@@ hdl/lbcs_front.sv @@
module lbcs_front import lbcs_pkg::*; (
    input  logic                 i_s_tvalid,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // row, left_x, right_x, start_row, end_row
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // kind
    input  logic                 i_q_full,
    output logic                 o_s_tready,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [SCAN_W-1:0] start_r;
    logic [SCAN_W-1:0] end_r;
    logic [SCAN_W-1:0] lo_raw;
    logic [SCAN_W-1:0] hi_raw;

    function automatic logic [SCAN_W-1:0] clamp(input logic [SCAN_W-1:0] v);
        if (v > SCAN_W'(SEARCH_HIGH)) begin
            return SCAN_W'(SEARCH_HIGH);
        end else if (v < SCAN_W'(SEARCH_LOW)) begin
            return SCAN_W'(SEARCH_LOW);
        end
        return v;
    endfunction

    assign start_r = SCAN_W'(i_s_tdata[29:23]);
    assign end_r   = SCAN_W'(i_s_tdata[36:30]);
    assign lo_raw  = (start_r > end_r) ? end_r : start_r;
    assign hi_raw  = (start_r > end_r) ? start_r : end_r;

    assign o_s_tready = !i_q_full;
    // An unused kind is taken off the bus and dropped here.
    assign o_push     = i_s_tvalid && !i_q_full && (i_s_tuser != KIND_NONE);

    always_comb begin
        o_cmd.kind = i_s_tuser;
        o_cmd.lx   = i_s_tdata[14:7];
        o_cmd.rx   = i_s_tdata[22:15];
        if (i_s_tuser == KIND_WRITE) begin
            o_cmd.lo = SCAN_W'(i_s_tdata[6:0]);
            o_cmd.hi = '0;
        end else begin
            o_cmd.lo = clamp(lo_raw);
            o_cmd.hi = clamp(hi_raw);
        end
    end

endmodule

@@ hdl/lbcs_queue.sv @@
module lbcs_queue import lbcs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W = $clog2(QDEPTH + 1);

    t_cmd            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;

    function automatic logic [QA_W-1:0] bump(input logic [QA_W-1:0] p);
        return (p == QA_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QC_W'(QDEPTH));
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hdl/lbcs_back.sv @@
module lbcs_back import lbcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [ROW_W-1:0] o_left_row,
    output logic [ROW_W-1:0] o_right_row
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;

    logic [COL_W-1:0]  mem_l [ROWS];
    logic [COL_W-1:0]  mem_r [ROWS];
    logic [COL_W-1:0]  r_lrd;
    logic [COL_W-1:0]  r_rrd;

    logic [SCAN_W-1:0] r_addr;
    logic [SCAN_W-1:0] r_last;
    logic [SCAN_W-1:0] r_row;
    logic [SCAN_W-1:0] r_hi;
    logic [SCAN_W-1:0] r_lf;
    logic [SCAN_W-1:0] r_rf;
    logic [SCAN_W-1:0] n_lf;
    logic [SCAN_W-1:0] n_rf;
    logic              r_up;
    logic              r_rd_v;
    logic              r_fresh;
    logic [WCNT_W-1:0] r_wcnt;
    t_win              r_lwin;
    t_win              r_rwin;
    logic              r_res_valid;
    logic [ROW_W-1:0]  r_left;
    logic [ROW_W-1:0]  r_right;

    logic              is_search;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic              rd_issue;
    logic [ADDR_W-1:0] rd_addr;
    logic              eval;
    logic              lc;
    logic              rc;
    logic              scan_end;
    logic              out_free;
    logic [SCAN_W-1:0] row_gap;
    logic              tear;

    assign is_search = (i_cmd.kind == KIND_LOWER) || (i_cmd.kind == KIND_UPPER);
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign we        = o_cmd_pop && (i_cmd.kind == KIND_WRITE) && (i_cmd.lo < SCAN_W'(ROWS));
    assign wa        = ADDR_W'(i_cmd.lo);

    // Neighbor rows past the table end wrap around to its start.
    assign rd_issue  = (r_state == ST_SCAN) && (r_addr <= r_last);
    assign rd_addr   = (r_addr >= SCAN_W'(ROWS)) ? ADDR_W'(r_addr - SCAN_W'(ROWS))
                                                 : ADDR_W'(r_addr);

    assign eval      = (r_state == ST_SCAN) && r_fresh && (r_wcnt == WCNT_W'(WIN));
    assign lc        = corner(r_lwin, r_up, 1'b1, i_cfg);
    assign rc        = corner(r_rwin, r_up, 1'b0, i_cfg);
    assign n_lf      = (eval && (r_lf == '0) && lc) ? r_row : r_lf;
    assign n_rf      = (eval && (r_rf == '0) && rc) ? r_row : r_rf;
    // Once both sides are found nothing can change, so the scan may stop.
    assign scan_end  = eval && ((r_row == r_hi) || ((n_lf != '0) && (n_rf != '0)));

    assign out_free  = !r_res_valid || i_res_ready;
    assign row_gap   = (r_lf > r_rf) ? r_lf - r_rf : r_rf - r_lf;
    assign tear      = CMP_W'(row_gap) >= CMP_W'(i_cfg.tear);

    assign o_res_valid = r_res_valid;
    assign o_left_row  = r_left;
    assign o_right_row = r_right;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd_pop && is_search) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_l[wa] <= i_cmd.lx;
            mem_r[wa] <= i_cmd.rx;
        end
        r_lrd <= mem_l[rd_addr];
        r_rrd <= mem_r[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_v      <= 1'b0;
            r_fresh     <= 1'b0;
            r_wcnt      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= rd_issue && !scan_end;
            r_fresh <= (r_state == ST_SCAN) && r_rd_v && !scan_end;
            if (o_cmd_pop) begin
                r_wcnt <= '0;
            end else if ((r_state == ST_SCAN) && r_rd_v && (r_wcnt != WCNT_W'(WIN))) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && is_search) begin
            r_addr <= i_cmd.lo - SCAN_W'(WIN_C);
            r_last <= i_cmd.hi + SCAN_W'(WIN_C);
            r_row  <= i_cmd.lo;
            r_hi   <= i_cmd.hi;
            r_up   <= (i_cmd.kind == KIND_UPPER);
            r_lf   <= '0;
            r_rf   <= '0;
        end else begin
            if (rd_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (eval) begin
                r_row <= r_row + 1'b1;
            end
            r_lf <= n_lf;
            r_rf <= n_rf;
        end
        if ((r_state == ST_SCAN) && r_rd_v) begin
            r_lwin <= {r_lrd, r_lwin[WIN-1:1]};
            r_rwin <= {r_rrd, r_rwin[WIN-1:1]};
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_left  <= tear ? '0 : ROW_W'(r_lf);
            r_right <= tear ? '0 : ROW_W'(r_rf);
        end
    end

endmodule

@@ hdl/lane_boundary_corner_search.sv @@
// Lane boundary corner search. Words on the input stream either load one row of the
// left and right boundary tables (kind 0), or ask for the lower (kind 1) or upper
// (kind 2) corners between two rows; kind 3 is taken and dropped. Only searches
// produce an output word, carrying the left and right corner rows, 0 meaning none.
// The search bounds are ordered and clamped to rows 5..110 before the scan. Rows
// must be loaded before a search reads them. Input words go into a two-entry queue,
// so the bus keeps moving while a search is at work until that queue is full. The
// back end writes a row load into the tables as it takes it from the queue. A search
// reads one row per cycle from each table: nine reads fill the window around the
// first candidate row, then one more per further row; it ends early as soon as both
// corners are found. The user must write thresholds on the configuration port only
// while the block is idle; the block does not enforce this. The port is always ready.
module lane_boundary_corner_search import lbcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // row, left_x, right_x, start_row, end_row
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // kind
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // left_row, right_row
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             push;
    t_cmd             fr_cmd;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_cmd             q_cmd;
    logic [ROW_W-1:0] left_row;
    logic [ROW_W-1:0] right_row;
    logic [ROW_W-1:0] out_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flat <= 8'd3;
            r_cfg.near <= 8'd7;
            r_cfg.mid  <= 8'd8;
            r_cfg.far  <= 8'd9;
            r_cfg.tear <= 7'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLAT: r_cfg.flat <= i_cfg_data;
                CFG_NEAR: r_cfg.near <= i_cfg_data;
                CFG_MID:  r_cfg.mid  <= i_cfg_data;
                CFG_FAR:  r_cfg.far  <= i_cfg_data;
                CFG_TEAR: r_cfg.tear <= i_cfg_data[TEAR_W-1:0];
                default: ;
            endcase
        end
    end

    lbcs_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_s_tready (o_s_tready),
        .o_push     (push),
        .o_cmd      (fr_cmd)
    );

    lbcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (fr_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    lbcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_left_row  (left_row),
        .o_right_row (right_row)
    );

    assign o_m_tdata = {2'b00, right_row, left_row};
    assign out_dist  = (left_row > right_row) ? left_row - right_row : right_row - left_row;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command taken from an empty queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (left_row == '0) ||
                       ((int'(left_row) >= SEARCH_LOW) && (int'(left_row) <= SEARCH_HIGH)))
        else $error("left corner outside the search range");

    a_tear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((left_row != '0) || (right_row != '0)) |->
            (out_dist < r_cfg.tear))
        else $error("reported corners exceed the tear limit");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lbcs_pkg::*;

    // Input word fields, lowest bits first: row, left_x, right_x, start_row, end_row.
    typedef struct packed {
        logic [ROW_W-1:0] end_row;
        logic [ROW_W-1:0] start_row;
        logic [COL_W-1:0] right_x;
        logic [COL_W-1:0] left_x;
        logic [ROW_W-1:0] row;
    } t_lane_item;

    // Output word fields, lowest bits first: left_row, right_row.
    typedef struct packed {
        logic [ROW_W-1:0] right_row;
        logic [ROW_W-1:0] left_row;
    } t_corner_pair;

    class corner_predictor;
        logic [COL_W-1:0] left_col[ROWS];
        logic [COL_W-1:0] right_col[ROWS];
        int flat_tol;
        int jmp_near;
        int jmp_mid;
        int jmp_far;
        int tear;
        t_corner_pair expected_corners[$];
        int errors;

        function new();
            flat_tol = 3;
            jmp_near = 7;
            jmp_mid  = 8;
            jmp_far  = 9;
            tear     = 50;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_FLAT: flat_tol = int'(val);
                CFG_NEAR: jmp_near = int'(val);
                CFG_MID:  jmp_mid  = int'(val);
                CFG_FAR:  jmp_far  = int'(val);
                CFG_TEAR: tear     = int'(val[TEAR_W-1:0]);
                default: ;
            endcase
        endfunction

        function int col_at(bit left, int r);
            int idx;
            idx = ((r % ROWS) + ROWS) % ROWS;
            return left ? int'(left_col[idx]) : int'(right_col[idx]);
        endfunction

        function int gap(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // dir +1 looks for a flat run below and jumps above, dir -1 the reverse.
        function bit is_corner(bit left, int i, int dir);
            int c;
            int sgn;
            c   = col_at(left, i);
            sgn = left ? 1 : -1;
            for (int k = 0; k < 3; k++) begin
                if (gap(col_at(left, i - dir * k), col_at(left, i - dir * (k + 1))) > flat_tol)
                    return 0;
            end
            if (sgn * (c - col_at(left, i + dir * 2)) < jmp_near) return 0;
            if (sgn * (c - col_at(left, i + dir * 3)) < jmp_mid) return 0;
            if (sgn * (c - col_at(left, i + dir * 4)) < jmp_far) return 0;
            return 1;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, t_lane_item item);
            int lo;
            int hi;
            int t;
            int dir;
            int lf;
            int rf;
            t_corner_pair pair;
            if (kind == KIND_WRITE) begin
                left_col[item.row]  = item.left_x;
                right_col[item.row] = item.right_x;
                return;
            end
            if (kind != KIND_LOWER && kind != KIND_UPPER)
                return;
            dir = (kind == KIND_LOWER) ? 1 : -1;
            lo  = int'(item.start_row);
            hi  = int'(item.end_row);
            lf  = 0;
            rf  = 0;
            if (lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            if (lo > SEARCH_HIGH) lo = SEARCH_HIGH;
            if (lo < SEARCH_LOW) lo = SEARCH_LOW;
            if (hi > SEARCH_HIGH) hi = SEARCH_HIGH;
            if (hi < SEARCH_LOW) hi = SEARCH_LOW;
            for (int i = lo; i <= hi; i++) begin
                if (lf == 0 && is_corner(1, i, dir)) lf = i;
                if (rf == 0 && is_corner(0, i, dir)) rf = i;
                // The upper search also wants the row above both corners in order.
                if (lf != 0 && rf != 0 && col_at(1, lf) < col_at(0, rf) &&
                    (dir == 1 || col_at(1, lf + 1) < col_at(0, rf + 1)))
                    break;
            end
            // A lone corner is tested against row 0 as well.
            if (gap(lf, rf) >= tear) begin
                lf = 0;
                rf = 0;
            end
            pair.left_row  = lf[ROW_W-1:0];
            pair.right_row = rf[ROW_W-1:0];
            expected_corners.push_back(pair);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] word);
            t_corner_pair got;
            t_corner_pair want;
            got = word[2*ROW_W-1:0];
            if (expected_corners.size() == 0) begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = expected_corners.pop_front();
            if (got.left_row !== want.left_row) begin
                $error("left_row expected %0d actual %0d", want.left_row, got.left_row);
                errors++;
            end
            if (got.right_row !== want.right_row) begin
                $error("right_row expected %0d actual %0d", want.right_row, got.right_row);
                errors++;
            end
        endfunction

        function int pending();
            return expected_corners.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    corner_predictor pred = new();
    int burst_left = 0;
    int items_sent = 0;
    int ready_mode = 0;
    int mode_left = 0;

    lane_boundary_corner_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: check accepted words, then pick the next ready value.
    always @(posedge clk) begin
        if (m_tvalid === 1'b1 && m_tready)
            pred.check_word(m_tdata);
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(30, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    task automatic send_item(logic [KIND_W-1:0] kind, t_lane_item item);
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - $bits(t_lane_item)){1'b0}}, item};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pred.note_item(kind, item);
        if (kind != KIND_NONE)
            items_sent++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_lane_item random_item();
        t_lane_item item;
        item.row       = ROW_W'($urandom_range(0, ROWS - 1));
        item.left_x    = COL_W'($urandom_range(0, 255));
        item.right_x   = COL_W'($urandom_range(0, 255));
        item.start_row = ROW_W'($urandom_range(0, 127));
        item.end_row   = ROW_W'($urandom_range(0, 127));
        return item;
    endfunction

    task automatic write_row(int r, int lx, int rx);
        t_lane_item item;
        item         = random_item();
        item.row     = ROW_W'(r);
        item.left_x  = COL_W'(lx);
        item.right_x = COL_W'(rx);
        send_item(KIND_WRITE, item);
    endtask

    task automatic search(logic [KIND_W-1:0] kind, int s0, int s1);
        t_lane_item item;
        item           = random_item();
        item.start_row = ROW_W'(s0);
        item.end_row   = ROW_W'(s1);
        send_item(kind, item);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        pred.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_thresholds(int flat, int near, int mid, int far, int tear);
        cfg_write(CFG_FLAT, CFG_DAT_W'(flat));
        cfg_write(CFG_NEAR, CFG_DAT_W'(near));
        cfg_write(CFG_MID, CFG_DAT_W'(mid));
        cfg_write(CFG_FAR, CFG_DAT_W'(far));
        cfg_write(CFG_TEAR, CFG_DAT_W'(tear));
    endtask

    // Hold the sender until every search has answered and queued writes have retired.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pred.pending() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    // Column of one side at row r: flat around base, ramping away past corner row c.
    function automatic int boundary_col(int base, int c, int r, int dir, int step,
                                        bit left, bit shaped, int nmax);
        int v;
        int d;
        v = base + $urandom_range(0, nmax);
        d = (r - c) * dir;
        if (shaped && d > 0)
            v = left ? base - step * d : base + step * d;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    function automatic int clamp_row(int r);
        return (r < 0) ? 0 : (r > 127) ? 127 : r;
    endfunction

    // Paint a lower or upper corner pair into the tables and search around it.
    task automatic corner_frame();
        int dir;
        int cl;
        int cr;
        int off;
        int side;
        int base_l;
        int base_r;
        int t;
        int step_l;
        int step_r;
        int nmax;
        int s0;
        int s1;
        logic [KIND_W-1:0] kind;
        dir    = $urandom_range(0, 1) ? 1 : -1;
        base_l = $urandom_range(20, 120);
        base_r = $urandom_range(130, 235);
        if ($urandom_range(0, 5) == 0) begin
            t      = base_l;
            base_l = base_r;
            base_r = t;
        end
        cl  = $urandom_range(9, 105);
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
        cr  = $urandom_range(0, 1) ? cl + off : cl - off;
        if (cr < 9) cr = 9;
        if (cr > 105) cr = 105;
        side   = $urandom_range(0, 5);
        nmax   = (pred.flat_tol < 3) ? pred.flat_tol : 3;
        step_l = $urandom_range(1, 14);
        step_r = $urandom_range(1, 14);
        for (int r = 1; r <= 114; r++) begin
            if ((r >= cl - 5 && r <= cl + 5) || (r >= cr - 5 && r <= cr + 5))
                write_row(r, boundary_col(base_l, cl, r, dir, step_l, 1, side != 1, nmax),
                          boundary_col(base_r, cr, r, dir, step_r, 0, side != 0, nmax));
        end
        repeat ($urandom_range(1, 3)) begin
            kind = ((dir == 1) ^ ($urandom_range(0, 4) == 0)) ? KIND_LOWER : KIND_UPPER;
            s0   = ((cl < cr) ? cl : cr) - $urandom_range(0, 12);
            s1   = ((cl > cr) ? cl : cr) + $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) begin
                s0 = $urandom_range(0, 127);
                s1 = $urandom_range(0, 127);
            end
            if ($urandom_range(0, 1))
                search(kind, clamp_row(s0), clamp_row(s1));
            else
                search(kind, clamp_row(s1), clamp_row(s0));
        end
    endtask

    task automatic random_phase(int count);
        int first;
        int pick;
        t_lane_item item;
        first = items_sent;
        while (items_sent - first < count) begin
            pick = $urandom_range(0, 19);
            item = random_item();
            if (pick < 12)
                corner_frame();
            else if (pick < 16)
                send_item($urandom_range(0, 1) ? KIND_LOWER : KIND_UPPER, item);
            else if (pick < 19)
                send_item(KIND_WRITE, item);
            else
                send_item(KIND_NONE, item);
        end
    endtask

    initial begin
        t_lane_item item;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every row gets written first, so no search ever reads an empty entry.
        for (int r = 0; r < ROWS; r++) begin
            if (r == 0 || r == 51)
                write_row(r, 0, 255);
            else if (r == 50 || r == ROWS - 1)
                write_row(r, 255, 0);
            else
                write_row(r, $urandom_range(0, 255), $urandom_range(0, 255));
        end

        // Bound ordering and clamping at both ends of the window, plus two dropped kind-3 words.
        search(KIND_LOWER, 0, 127);
        search(KIND_UPPER, 127, 0);
        search(KIND_LOWER, 0, 0);
        search(KIND_UPPER, 127, 127);
        search(KIND_LOWER, 110, 5);
        search(KIND_UPPER, 5, 110);
        search(KIND_LOWER, 40, 20);
        search(KIND_UPPER, 111, 4);
        item = '1;
        send_item(KIND_NONE, item);
        item = '0;
        send_item(KIND_NONE, item);
        search(KIND_LOWER, 127, 0);

        random_phase(50);
        for (int p = 1; p <= 6; p++) begin
            drain();
            case (p)
                1: write_thresholds(0, 0, 0, 0, 0);
                2: write_thresholds(255, 255, 255, 255, 255);
                3: write_thresholds(3, 7, 8, 9, 50);
                4: write_thresholds($urandom_range(0, 6), $urandom_range(1, 20),
                                    $urandom_range(1, 24), $urandom_range(1, 28),
                                    $urandom_range(0, 255));
                5: write_thresholds(255, 1, 1, 1, 127);
                default: write_thresholds($urandom_range(0, 255), $urandom_range(0, 30),
                                          $urandom_range(0, 30), $urandom_range(0, 30),
                                          $urandom_range(0, 255));
            endcase
            random_phase(50);
        end

        drain();
        if (pred.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
